// ===== hw/rtl/date_day_distance_assert.svh =====
// ----------------------------------------------------------------------------
// date_day_distance_assert
// Assertion macros used by the date_day_distance top level.
// ----------------------------------------------------------------------------
`ifndef DATE_DAY_DISTANCE_ASSERT_SVH
`define DATE_DAY_DISTANCE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DDD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ddd_pkg.sv =====
// ----------------------------------------------------------------------------
// ddd_pkg
// Types, widths and constants of the Gregorian date distance pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddd_pkg;

   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 14;
   localparam int DIST_W     = 22;
   localparam int DAY_NUM_W  = 23;
   localparam int DOY_W      = 9;
   localparam int QUOT_W     = 13;
   localparam int PROD_W     = 26;

   // largest year taken as given, later years are saturated
   localparam int MAX_YEAR   = 9999;
   localparam logic [YEAR_W-1:0] MAX_YEAR_CLIP = YEAR_W'(MAX_YEAR);

   // x / 25 == (x * RECIP_25) >> RECIP_SHIFT for x below 2**13
   localparam logic [QUOT_W-1:0] RECIP_25    = QUOT_W'(5243);
   localparam int                RECIP_SHIFT = 17;
   localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;

   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

   typedef struct packed {
      logic [DAY_W-1:0]   start_day;
      logic [MONTH_W-1:0] start_month;
      logic [YEAR_W-1:0]  start_year;
      logic [DAY_W-1:0]   end_day;
      logic [MONTH_W-1:0] end_month;
      logic [YEAR_W-1:0]  end_year;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] day_distance;
      logic              order_error;
   } rsp_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   // days before the first of a month in an ordinary year;
   // month zero counts as january, months past twelve as december
   function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] mon);
      logic [DOY_W-1:0] days;
      unique case (mon)
         4'd0, 4'd1: days = 9'd0;
         4'd2:       days = 9'd31;
         4'd3:       days = 9'd59;
         4'd4:       days = 9'd90;
         4'd5:       days = 9'd120;
         4'd6:       days = 9'd151;
         4'd7:       days = 9'd181;
         4'd8:       days = 9'd212;
         4'd9:       days = 9'd243;
         4'd10:      days = 9'd273;
         4'd11:      days = 9'd304;
         default:    days = 9'd334;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/date_day_distance.sv =====
// Gregorian date distance: takes a start and an end date (day, month, year) and
// returns the days from start to end, or an order error with zero days when the
// start lies after the end. One item is accepted every clock cycle while the
// pipeline advances; each passes through five register stages (date clean-up,
// divide-by-25 multipliers, leap count, day-number sum, compare and subtract).
// The whole pipeline advances together whenever the output register is empty or
// its item is being taken, so rsp_stall with rsp_valid high holds req_stall high
// in the same cycle. Day fields are not checked against month length, month zero
// counts as January, months past twelve as December, and years past MAX_YEAR are
// saturated.
// ----------------------------------------------------------------------------
// date_day_distance
// Top level of the pipelined Gregorian day-distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "date_day_distance_assert.svh"

module date_day_distance (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ddd_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ddd_pkg::rsp_type       rsp_data
);

   localparam int NW = ddd_pkg::DAY_NUM_W;
   localparam int DEPTH = 4;

   logic advance;
   ddd_pkg::date_type start_date, end_date;
   logic [NW-1:0] start_num, end_num;

   // pipeline moves when the output register can take a new item
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   assign start_date = '{day: req_data.start_day, month: req_data.start_month,
                         year: req_data.start_year};
   assign end_date   = '{day: req_data.end_day, month: req_data.end_month,
                         year: req_data.end_year};

   // day numbers of both dates
   ddd_day_num u_start_num (
      .clock       (clock),
      .enable      (advance),
      .date_in     (start_date),
      .day_num_out (start_num)
   );

   ddd_day_num u_end_num (
      .clock       (clock),
      .enable      (advance),
      .date_in     (end_date),
      .day_num_out (end_num)
   );

   // valid bits that travel beside the day-number stages
   logic [DEPTH-1:0] vld_ff, vld_in;

   assign vld_in = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // stage 5: order check and subtraction into the output register
   ddd_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   always_comb begin
      if (start_num > end_num) begin
         rsp_in.day_distance = '0;
         rsp_in.order_error  = 1'b1;
      end else begin
         rsp_in.day_distance = ddd_pkg::DIST_W'(end_num - start_num);
         rsp_in.order_error  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `DDD_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid_ff && rsp_ff.order_error, rsp_ff.day_distance == '0, "order error with nonzero distance")
   `DDD_ASSERT_NEXT(a_last_to_out, clock, reset, advance && vld_ff[DEPTH-1], rsp_valid_ff, "item lost between last stage and output")
   `DDD_ASSERT_NEXT(a_hold_vld, clock, reset, !advance, $stable(vld_ff) && rsp_valid_ff, "pipeline moved while stalled")

endmodule

`default_nettype wire

// ===== hw/rtl/ddd_day_num.sv =====
// ----------------------------------------------------------------------------
// ddd_day_num
// Four-stage pipeline turning one date into its running day number:
// 365 * year + leap years before it + day of the year.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddd_day_num (
   input  wire logic                            clock,
   input  wire logic                            enable,
   input  wire ddd_pkg::date_type               date_in,
   output logic [ddd_pkg::DAY_NUM_W-1:0]        day_num_out
);

   localparam int YW = ddd_pkg::YEAR_W;
   localparam int QW = ddd_pkg::QUOT_W;
   localparam int PW = ddd_pkg::PROD_W;
   localparam int DW = ddd_pkg::DOY_W;
   localparam int NW = ddd_pkg::DAY_NUM_W;
   localparam int SH = ddd_pkg::RECIP_SHIFT;

   // stage 1: saturate year, month table, offset years for the leap counts
   logic [YW-1:0] yr_sat;
   logic [YW:0]   sum_3;
   logic [YW:0]   sum_99;
   logic [YW:0]   sum_399;

   logic [YW-1:0] yr1_ff,  yr1_in;
   logic [QW-1:0] a1_ff,   a1_in;
   logic [QW-1:0] b1_ff,   b1_in;
   logic [QW-1:0] c1_ff,   c1_in;
   logic [QW-1:0] g1_ff,   g1_in;
   logic [DW-1:0] doy1_ff, doy1_in;
   logic          late1_ff, late1_in;

   always_comb begin
      if (32'(date_in.year) > ddd_pkg::MAX_YEAR) yr_sat = ddd_pkg::MAX_YEAR_CLIP;
      else yr_sat = date_in.year;
      sum_3    = {1'b0, yr_sat} + (YW+1)'(3);
      sum_99   = {1'b0, yr_sat} + (YW+1)'(99);
      sum_399  = {1'b0, yr_sat} + (YW+1)'(399);
      yr1_in   = yr_sat;
      a1_in    = sum_3[YW:2];
      b1_in    = sum_99[YW:2];
      c1_in    = QW'(sum_399[YW:4]);
      g1_in    = QW'(yr_sat[YW-1:2]);
      doy1_in  = ddd_pkg::days_before_month(date_in.month) + DW'(date_in.day);
      late1_in = date_in.month > ddd_pkg::MONTH_FEB;
   end

   // stage 2: divide by 25 through the reciprocal, year times 365
   logic [PW-1:0] pb2_ff,  pb2_in;
   logic [PW-1:0] pc2_ff,  pc2_in;
   logic [PW-1:0] pg2_ff,  pg2_in;
   logic [NW-1:0] y365_2_ff, y365_2_in;
   logic [QW-1:0] a2_ff;
   logic [QW-1:0] g2_ff;
   logic [DW-1:0] doy2_ff;
   logic          late2_ff;
   logic [1:0]    ylo2_ff;

   always_comb begin
      pb2_in    = PW'(b1_ff) * PW'(ddd_pkg::RECIP_25);
      pc2_in    = PW'(c1_ff) * PW'(ddd_pkg::RECIP_25);
      pg2_in    = PW'(g1_ff) * PW'(ddd_pkg::RECIP_25);
      y365_2_in = NW'(yr1_ff) * NW'(ddd_pkg::DAYS_PER_YEAR);
   end

   // stage 3: leap test and count of leap years before this year
   logic [QW-1:0] qb, qc, qg;
   logic [QW-1:0] rem25;
   logic          leap;

   logic [NW-1:0] y365_3_ff;
   logic [QW-1:0] leaps3_ff, leaps3_in;
   logic [DW-1:0] doy3_ff,   doy3_in;

   always_comb begin
      qb    = QW'(pb2_ff[PW-1:SH]);
      qc    = QW'(pc2_ff[PW-1:SH]);
      qg    = QW'(pg2_ff[PW-1:SH]);
      // year / 4 modulo 25 is zero exactly when a multiple of four is one of 100
      rem25 = g2_ff - QW'(qg * QW'(25));
      leap  = (ylo2_ff == 2'd0) && ((rem25 != '0) || (qg[1:0] == 2'd0));
      leaps3_in = a2_ff - qb + qc;
      doy3_in   = doy2_ff + DW'(late2_ff && leap);
   end

   // stage 4: final sum
   logic [NW-1:0] num4_ff, num4_in;

   assign num4_in = y365_3_ff + NW'(leaps3_ff) + NW'(doy3_ff);

   // pipeline registers, all move together
   always_ff @(posedge clock) begin
      if (enable) begin
         yr1_ff    <= yr1_in;
         a1_ff     <= a1_in;
         b1_ff     <= b1_in;
         c1_ff     <= c1_in;
         g1_ff     <= g1_in;
         doy1_ff   <= doy1_in;
         late1_ff  <= late1_in;

         pb2_ff    <= pb2_in;
         pc2_ff    <= pc2_in;
         pg2_ff    <= pg2_in;
         y365_2_ff <= y365_2_in;
         a2_ff     <= a1_ff;
         g2_ff     <= g1_ff;
         doy2_ff   <= doy1_ff;
         late2_ff  <= late1_ff;
         ylo2_ff   <= yr1_ff[1:0];

         y365_3_ff <= y365_2_ff;
         leaps3_ff <= leaps3_in;
         doy3_ff   <= doy3_in;

         num4_ff   <= num4_in;
      end
   end

   assign day_num_out = num4_ff;

endmodule

`default_nettype wire

// ===== verif/date_day_distance_tb.sv =====
// ----------------------------------------------------------------------------
// date_day_distance_tb
// Self-checking bench for the Gregorian day-distance pipeline. A scoreboard
// predicts the day count and order flag of every accepted date pair and
// compares each returned item in order, under random input gaps and
// output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module date_day_distance_tb;

   localparam int RANDOM_ITEMS  = 1450;
   localparam int LONG_HOLD     = 80;
   localparam int DRAIN_CYCLES  = 20;

   // ---------------------------------------------------------------------------
   // scoreboard: predicts distances and checks returned items in order
   // ---------------------------------------------------------------------------
   class distance_scoreboard;
      ddd_pkg::rsp_type pending_distances[$];
      int               mismatches;

      function new();
         mismatches = 0;
      endfunction

      // days before the first of a month, ordinary year
      static function int unsigned month_start(int unsigned mon);
         case (mon)
            1:       return 0;
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            default: return 334;
         endcase
      endfunction

      static function bit leap_year(int unsigned yr);
         return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      endfunction

      // absolute day count from year zero, with clamped month and year
      static function int unsigned date_ordinal(logic [ddd_pkg::DAY_W-1:0] d,
                                                logic [ddd_pkg::MONTH_W-1:0] m,
                                                logic [ddd_pkg::YEAR_W-1:0] y);
         int unsigned yr;
         int unsigned mon;
         int unsigned doy;
         yr  = y;
         mon = m;
         if (yr > ddd_pkg::MAX_YEAR) yr = ddd_pkg::MAX_YEAR;
         if (mon < 1) mon = 1;
         if (mon > 12) mon = 12;
         doy = month_start(mon) + d;
         if (mon > 2 && leap_year(yr)) doy++;
         return 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400 + doy;
      endfunction

      static function ddd_pkg::rsp_type predict_distance(ddd_pkg::req_type r);
         ddd_pkg::rsp_type res;
         int unsigned      first;
         int unsigned      last;
         first = date_ordinal(r.start_day, r.start_month, r.start_year);
         last  = date_ordinal(r.end_day, r.end_month, r.end_year);
         if (first > last) begin
            res.day_distance = '0;
            res.order_error  = 1'b1;
         end else begin
            res.day_distance = ddd_pkg::DIST_W'(last - first);
            res.order_error  = 1'b0;
         end
         return res;
      endfunction

      function void note_dates(ddd_pkg::req_type r);
         pending_distances.push_back(predict_distance(r));
      endfunction

      function void check_distance(ddd_pkg::rsp_type got);
         ddd_pkg::rsp_type want;
         if (pending_distances.size() == 0) begin
            $display("%0t unexpected item: expected none, actual distance %0d error %0b",
                     $time, got.day_distance, got.order_error);
            mismatches++;
            return;
         end
         want = pending_distances.pop_front();
         if (got.day_distance !== want.day_distance) begin
            $display("%0t day_distance mismatch: expected %0d, actual %0d",
                     $time, want.day_distance, got.day_distance);
            mismatches++;
         end
         if (got.order_error !== want.order_error) begin
            $display("%0t order_error mismatch: expected %0b, actual %0b",
                     $time, want.order_error, got.order_error);
            mismatches++;
         end
      endfunction

      function int waiting();
         return pending_distances.size();
      endfunction
   endclass

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ddd_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ddd_pkg::rsp_type rsp_data;

   distance_scoreboard sb = new();

   bit hold_request = 1'b0;

   date_day_distance uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_dates(req_data);
         if (rsp_valid && !rsp_stall) sb.check_distance(rsp_data);
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   always begin : receiver
      int hold_left;
      int stretch_left;
      int stall_pct;
      hold_left    = 0;
      stretch_left = 0;
      stall_pct    = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(5, 60);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  2:       stall_pct = 50;
                  default: stall_pct = 80;
               endcase
            end
            stretch_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // give up after a generous fixed time
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // offer one item and hold it until taken
   task automatic offer(ddd_pkg::req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic go_idle(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // stop sending until every predicted item has come back
   task automatic drain();
      go_idle(1);
      while (sb.waiting() != 0) @(posedge clock);
   endtask

   function automatic ddd_pkg::req_type make_pair(int sd, int sm, int sy,
                                                  int ed, int em, int ey);
      ddd_pkg::req_type r;
      r.start_day   = ddd_pkg::DAY_W'(sd);
      r.start_month = ddd_pkg::MONTH_W'(sm);
      r.start_year  = ddd_pkg::YEAR_W'(sy);
      r.end_day     = ddd_pkg::DAY_W'(ed);
      r.end_month   = ddd_pkg::MONTH_W'(em);
      r.end_year    = ddd_pkg::YEAR_W'(ey);
      return r;
   endfunction

   // random years, half of them snapped onto a multiple of 400, 100 or 4
   function automatic int pick_year();
      int y;
      y = $urandom_range(1, ddd_pkg::MAX_YEAR);
      case ($urandom_range(0, 5))
         0:       y = y - y % 400;
         1:       y = y - y % 100;
         2:       y = y - y % 4;
         default: ;
      endcase
      return y;
   endfunction

   function automatic ddd_pkg::req_type random_pair();
      ddd_pkg::req_type r;
      ddd_pkg::req_type swapped;
      logic [63:0]      noise;
      int               kind;
      int               y;
      kind = $urandom_range(0, 9);
      r.start_day   = ddd_pkg::DAY_W'($urandom_range(1, 31));
      r.start_month = ddd_pkg::MONTH_W'($urandom_range(1, 12));
      r.end_day     = ddd_pkg::DAY_W'($urandom_range(1, 31));
      r.end_month   = ddd_pkg::MONTH_W'($urandom_range(1, 12));
      if (kind <= 5) begin
         // well-formed dates, mostly near each other
         y = pick_year();
         r.start_year = ddd_pkg::YEAR_W'(y);
         if ($urandom_range(0, 3) == 0)
            r.end_year = ddd_pkg::YEAR_W'(pick_year());
         else
            r.end_year = ddd_pkg::YEAR_W'((y + $urandom_range(0, 3) > ddd_pkg::MAX_YEAR) ?
                                          ddd_pkg::MAX_YEAR : y + $urandom_range(0, 3));
      end else if (kind == 6) begin
         // same leap-sensitive year, either order
         y = pick_year();
         r.start_year = ddd_pkg::YEAR_W'(y);
         r.end_year   = ddd_pkg::YEAR_W'(y);
      end else begin
         // raw field noise, covers every bit of every field
         noise = {$urandom, $urandom};
         r     = noise[$bits(ddd_pkg::req_type)-1:0];
      end
      // keep most well-formed pairs in order so distances dominate
      if (kind <= 5 && $urandom_range(0, 9) != 0 &&
          distance_scoreboard::predict_distance(r).order_error) begin
         swapped = r;
         swapped.start_day   = r.end_day;
         swapped.start_month = r.end_month;
         swapped.start_year  = r.end_year;
         swapped.end_day     = r.start_day;
         swapped.end_month   = r.start_month;
         swapped.end_year    = r.start_year;
         r = swapped;
      end
      return r;
   endfunction

   // main sequence
   initial begin : stimulus
      ddd_pkg::req_type directed[$];
      int               sent;
      int               burst;
      int               hold_at;
      int               pause_at;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // field extremes, leap rules and out-of-range fields
      directed.push_back(make_pair(1, 1, 1, 1, 1, 1));
      directed.push_back(make_pair(1, 1, 1, 31, 12, 9999));
      directed.push_back(make_pair(31, 12, 9999, 1, 1, 1));
      directed.push_back(make_pair(28, 2, 2000, 1, 3, 2000));
      directed.push_back(make_pair(28, 2, 1900, 1, 3, 1900));
      directed.push_back(make_pair(28, 2, 2004, 1, 3, 2004));
      directed.push_back(make_pair(28, 2, 2001, 1, 3, 2001));
      directed.push_back(make_pair(31, 12, 1999, 1, 1, 2000));
      directed.push_back(make_pair(1, 1, 1600, 1, 1, 2000));
      directed.push_back(make_pair(0, 3, 2020, 1, 3, 2020));
      directed.push_back(make_pair(31, 2, 2021, 1, 3, 2021));
      directed.push_back(make_pair(5, 0, 2020, 5, 1, 2020));
      directed.push_back(make_pair(1, 13, 2020, 1, 12, 2020));
      directed.push_back(make_pair(31, 15, 2020, 1, 1, 2021));
      directed.push_back(make_pair(1, 1, 0, 1, 1, 1));
      directed.push_back(make_pair(28, 2, 0, 1, 3, 0));
      directed.push_back(make_pair(1, 1, 16383, 1, 1, 9999));
      directed.push_back(make_pair(1, 1, 10000, 31, 12, 9999));
      directed.push_back(make_pair(0, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(31, 15, 16383, 31, 15, 16383));
      directed.push_back(make_pair(2, 1, 2023, 1, 1, 2023));
      directed.push_back(make_pair(0, 0, 0, 31, 15, 16383));
      directed.push_back(make_pair(31, 15, 16383, 0, 0, 0));
      directed.push_back(make_pair(1, 1, 0, 31, 12, 9999));

      foreach (directed[i]) offer(directed[i]);
      drain();

      // random bursts with gaps
      hold_at  = $urandom_range(100, 400);
      pause_at = $urandom_range(600, 900);
      sent     = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
         repeat (burst) begin
            if (sent == hold_at || sent == hold_at + 600) hold_request = 1'b1;
            if (sent == pause_at) drain();
            offer(random_pair());
            sent++;
         end
         go_idle($urandom_range(0, 8));
      end

      // wait out the pipeline, then report
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.waiting() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
